@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ src/blm_pkg.sv @@
// ---------------------------------------------------------------------------
// blm_pkg
// Types, widths and constants of the battery level monitor.
// ---------------------------------------------------------------------------
package blm_pkg;

	localparam int SAMPLE_DEPTH = 16;
	localparam int SAMPLE_BITS  = 12;

	localparam int RAW_W    = 12;
	localparam int GAIN_W   = 24;
	localparam int OFFS_W   = 12;
	localparam int VOLT_W   = 15;
	localparam int PCT_W    = 7;
	localparam int LEVEL_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int PTR_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int FILL_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLE_DEPTH);
	localparam int PROD_W = SUM_W + GAIN_W;
	localparam int Q_FRAC = 16;

	// average dividend is the product with the Q16 fraction dropped
	localparam int AVG_NUM_W = PROD_W - Q_FRAC;
	// (volt - empty) * 100
	localparam int PCT_NUM_W = VOLT_W + PCT_W;
	localparam int DIV_NUM_W = (AVG_NUM_W > PCT_NUM_W) ? AVG_NUM_W : PCT_NUM_W;
	// divisor is either fill count or a voltage span
	localparam int DIV_DEN_W = (FILL_W > VOLT_W) ? FILL_W : VOLT_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [VOLT_W-1:0] VOLT_MAX   = '1;
	localparam logic [PCT_W-1:0]  PCT_FULL   = PCT_W'(100);
	localparam logic [PCT_W-1:0]  PCT_GREEN_ABOVE = PCT_W'(40);
	localparam logic [PCT_W-1:0]  PCT_AMBER_ABOVE = PCT_W'(15);

	localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(105626);
	localparam logic [OFFS_W-1:0] OFFS_RST  = '0;
	localparam logic [VOLT_W-1:0] EMPTY_RST = VOLT_W'(3300);
	localparam logic [VOLT_W-1:0] FULL_RST  = VOLT_W'(4200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLT_GAIN,
		REG_VOLT_OFFSET,
		REG_CELL_EMPTY,
		REG_CELL_FULL
	} cfg_reg_t;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_RED,
		LVL_AMBER,
		LVL_GREEN
	} level_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_PCT_SETUP,
		ST_PCT_START,
		ST_PCT_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ src/blm_div.sv @@
// ---------------------------------------------------------------------------
// blm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module blm_div
	import blm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;   // dividend in, quotient out
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] diff;
	logic               ge;

	assign trial = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff : trial;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

@@ src/battery_level_monitor_top.sv @@
// ---------------------------------------------------------------------------
// battery_level_monitor_top
// Moving-average battery gauge: ring average, calibration, percent, level.
// ---------------------------------------------------------------------------
// One word on the sample channel gives one word on the result channel. Each
// sample enters a 16-entry ring held in a synchronous RAM; the block reads
// the slot it overwrites, corrects the running sum and writes the new sample
// back. The average over the samples held so far (all 16 once the ring has
// filled) is scaled by the Q16 gain, offset, saturated to 0..32767 mV, and
// turned into a truncated percent between the empty and full cell voltages
// and a red/amber/green level (green above 40 %, amber above 15 %). One
// sample is in work at a time. Most of the time goes to the shared
// bit-serial divider: once for the average and, unless the voltage lies at
// or outside the empty/full limits, once for the percent. A finished result
// sits in the output register, so the next sample is taken while it waits.
// After reset the ring reads as zeros through per-slot valid flags; there is
// no clearing pass. The user must see that registers are written only while
// the block is idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_level_monitor_top
	import blm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// sample word
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [RAW_W-1:0]      raw_sample,
	// result word
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [VOLT_W-1:0]     voltage_mv,
	output logic [PCT_W-1:0]      percent,
	output logic [LEVEL_W-1:0]    level
);

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic [OFFS_W-1:0] offs_q;
	logic [VOLT_W-1:0] empty_q;
	logic [VOLT_W-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			offs_q  <= OFFS_RST;
			empty_q <= EMPTY_RST;
			full_q  <= FULL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VOLT_GAIN:   gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_VOLT_OFFSET: offs_q  <= cfg_wdata[OFFS_W-1:0];
				REG_CELL_EMPTY:  empty_q <= cfg_wdata[VOLT_W-1:0];
				REG_CELL_FULL:   full_q  <= cfg_wdata[VOLT_W-1:0];
				default:         ;
			endcase
		end
	end

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   out_free;
	logic   mem_re, mem_we;
	logic   pct_low, pct_high;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !result_valid || !result_stall;

	// ring state
	logic [SAMPLE_BITS-1:0]  ring_mem [SAMPLE_DEPTH];
	logic [SAMPLE_BITS-1:0]  ring_rd_q;
	logic [SAMPLE_DEPTH-1:0] vld_q;     // slot written since reset
	logic [PTR_W-1:0]        wp_q;
	logic [FILL_W-1:0]       fill_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SAMPLE_BITS-1:0]  raw_q;
	logic [SAMPLE_BITS-1:0]  old_smp;

	assign old_smp = vld_q[wp_q] ? ring_rd_q : '0;

	// datapath
	logic [PROD_W-1:0]    prod_q;
	logic [VOLT_W-1:0]    volt_q;
	logic [PCT_W-1:0]     pct_q;
	logic [PCT_NUM_W-1:0] pnum_q;
	logic [VOLT_W-1:0]    pden_q;

	logic [DIV_NUM_W+1:0] mv_sum;      // signed: quotient plus offset
	logic [VOLT_W-1:0]    volt_sat;
	logic [VOLT_W-1:0]    volt_span;

	assign mv_sum = $signed({2'b00, div_rsp.quotient})
		+ $signed({{(DIV_NUM_W+2-OFFS_W){offs_q[OFFS_W-1]}}, offs_q});

	always_comb begin
		if (mv_sum[DIV_NUM_W+1])
			volt_sat = '0;
		else if (mv_sum[DIV_NUM_W:0] > (DIV_NUM_W+1)'(VOLT_MAX))
			volt_sat = VOLT_MAX;
		else
			volt_sat = mv_sum[VOLT_W-1:0];
	end

	assign pct_low   = volt_q <= empty_q;
	assign pct_high  = volt_q >= full_q;
	assign volt_span = volt_q - empty_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = ST_READ;
			ST_READ:      state_d = ST_MUL;
			ST_MUL:       state_d = ST_AVG_START;
			ST_AVG_START: state_d = ST_AVG_WAIT;
			ST_AVG_WAIT:  if (div_rsp.done) state_d = ST_PCT_SETUP;
			ST_PCT_SETUP: state_d = (pct_low || pct_high) ? ST_DONE : ST_PCT_START;
			ST_PCT_START: state_d = ST_PCT_WAIT;
			ST_PCT_WAIT:  if (div_rsp.done) state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		sample_stall     = (state_q != ST_IDLE);
		mem_re           = accept;
		mem_we           = (state_q == ST_READ);
		div_req.start    = (state_q == ST_AVG_START) || (state_q == ST_PCT_START);
		div_req.dividend = '0;
		div_req.divisor  = '0;
		if (state_q == ST_AVG_START) begin
			div_req.dividend = DIV_NUM_W'(prod_q[PROD_W-1:Q_FRAC]);
			div_req.divisor  = DIV_DEN_W'(fill_q);
		end else begin
			div_req.dividend = DIV_NUM_W'(pnum_q);
			div_req.divisor  = DIV_DEN_W'(pden_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ring RAM, one read port and one write port
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[wp_q] <= raw_q;
		if (mem_re)
			ring_rd_q <= ring_mem[wp_q];
	end

	// ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (mem_we) begin
			vld_q[wp_q] <= 1'b1;
			sum_q       <= sum_q - SUM_W'(old_smp) + SUM_W'(raw_q);
			wp_q        <= (wp_q == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != FILL_W'(SAMPLE_DEPTH))
				fill_q <= fill_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept)
			raw_q <= raw_sample[SAMPLE_BITS-1:0];
		if (state_q == ST_MUL)
			prod_q <= PROD_W'(sum_q) * PROD_W'(gain_q);
		if (state_q == ST_AVG_WAIT && div_rsp.done)
			volt_q <= volt_sat;
		if (state_q == ST_PCT_SETUP) begin
			pnum_q <= PCT_NUM_W'(volt_span) * PCT_NUM_W'(PCT_FULL);
			pden_q <= full_q - empty_q;
			if (pct_low)
				pct_q <= '0;
			else if (pct_high)
				pct_q <= PCT_FULL;
		end
		if (state_q == ST_PCT_WAIT && div_rsp.done)
			pct_q <= div_rsp.quotient[PCT_W-1:0];   // below 100 here
	end

	blm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register
	logic              res_valid_q;
	logic [VOLT_W-1:0] res_volt_q;
	logic [PCT_W-1:0]  res_pct_q;
	level_t            res_lvl_q;
	level_t            lvl_d;

	always_comb begin
		if (pct_q > PCT_GREEN_ABOVE)
			lvl_d = LVL_GREEN;
		else if (pct_q > PCT_AMBER_ABOVE)
			lvl_d = LVL_AMBER;
		else
			lvl_d = LVL_RED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_volt_q <= volt_q;
			res_pct_q  <= pct_q;
			res_lvl_q  <= lvl_d;
		end
	end

	assign result_valid = res_valid_q;
	assign voltage_mv   = res_volt_q;
	assign percent      = res_pct_q;
	assign level        = res_lvl_q;

	// checks
	`ASSERT_NEVER(a_fill_range, fill_q > FILL_W'(SAMPLE_DEPTH), "fill count beyond ring depth")
	`ASSERT_CLK(a_pct_range, result_valid |-> percent <= PCT_FULL, "percent above 100")
	`ASSERT_CLK(a_div_owner, div_rsp.done |-> (state_q == ST_AVG_WAIT || state_q == ST_PCT_WAIT), "divider result with no waiting stage")
	`ASSERT_CLK(a_lvl_match, result_valid |-> ((level == LVL_GREEN) == (percent > PCT_GREEN_ABOVE)), "level disagrees with percent")

endmodule

@@ tb/battery_level_monitor_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// battery_level_monitor_top_tb
// Self-checking bench for the moving-average battery gauge.
// ---------------------------------------------------------------------------
// A tracker class keeps its own copy of the sample ring, the running sum, the
// fill count and the calibration registers. For every sample word taken by
// the block it works out the reading (millivolts, percent, level) that must
// come back. Each result word is checked field by field against the oldest
// reading still due. A short directed part runs first, then phases of random
// samples, each phase under its own calibration, written while the block is
// idle. Both sides idle in random bursts; once per ten phases, before the
// tail, the result side holds off for a long stretch so the block backs up
// onto its input.
// ---------------------------------------------------------------------------

module battery_level_monitor_top_tb;

	import blm_pkg::*;

	localparam int          ITEMS_TOTAL   = 1850;
	localparam int          TAIL_ITEMS    = 200;   // no idling at the end of the run
	localparam int          LONG_HOLD     = 400;   // result side hold-off, cycles
	localparam int          SETTLE_CYCLES = 80;    // longer than the latency of one sample
	localparam int          REPORT_CAP    = 200;   // later mismatches are counted only
	localparam int          RAW_MAX       = (1 << RAW_W) - 1;
	localparam int          CELL_MAX      = 20000;
	localparam int          OFFS_LIMIT    = 2000;
	localparam int unsigned TIMEOUT_NS    = 4_000_000;

	// warm-up samples: fill ramp through the first sixteen, extremes and
	// alternating bit patterns on the way
	localparam logic [RAW_W-1:0] WARMUP [16] = '{
		12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000,
		12'h800, 12'h7FF, 12'h9C4, 12'h8FC, 12'hA00, 12'h001, 12'hFFE, 12'h000
	};

	typedef struct {
		logic [VOLT_W-1:0] volt;
		logic [PCT_W-1:0]  pct;
		level_t            lvl;
	} reading_t;

	// -----------------------------------------------------------------------
	// tracker: mirrors the gauge state and holds the readings still due
	// -----------------------------------------------------------------------
	class gauge_tracker;
		logic [RAW_W-1:0]         ring [SAMPLE_DEPTH];
		logic [PTR_W-1:0]         wr_ptr    = '0;
		logic [FILL_W-1:0]        fill      = '0;
		logic [SUM_W-1:0]         ring_sum  = '0;
		logic [GAIN_W-1:0]        gain_q16  = GAIN_RST;
		logic signed [OFFS_W-1:0] offset_mv = OFFS_RST;
		logic [VOLT_W-1:0]        empty_mv  = EMPTY_RST;
		logic [VOLT_W-1:0]        full_mv   = FULL_RST;
		reading_t                 readings_due [$];
		int unsigned              faults    = 0;

		function new();
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void set_calibration(logic [GAIN_W-1:0] gain, logic [OFFS_W-1:0] offs,
				logic [VOLT_W-1:0] empty_v, logic [VOLT_W-1:0] full_v);
			gain_q16  = gain;
			offset_mv = $signed(offs);
			empty_mv  = empty_v;
			full_mv   = full_v;
		endfunction

		function void take_sample(logic [RAW_W-1:0] raw);
			longint unsigned prod;
			longint          mv;
			reading_t        r;
			// overwrite the oldest slot, sum follows the ring contents
			ring_sum     = ring_sum - ring[wr_ptr] + raw;
			ring[wr_ptr] = raw;
			wr_ptr = (wr_ptr == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
			if (fill < FILL_W'(SAMPLE_DEPTH))
				fill = fill + 1'b1;
			// average over stored samples, scaled by the Q16 gain in one quotient
			prod = ring_sum;
			prod = prod * gain_q16;
			prod = prod / (64'(fill) << Q_FRAC);
			mv   = longint'(prod) + offset_mv;
			if (mv < 0)
				r.volt = '0;
			else if (mv > longint'(VOLT_MAX))
				r.volt = VOLT_MAX;
			else
				r.volt = VOLT_W'(mv);
			// full at or below empty never reaches the division
			if (r.volt <= empty_mv)
				r.pct = '0;
			else if (r.volt >= full_mv)
				r.pct = PCT_FULL;
			else
				r.pct = PCT_W'((int'(r.volt) - int'(empty_mv)) * int'(PCT_FULL) /
					(int'(full_mv) - int'(empty_mv)));
			if (r.pct > PCT_GREEN_ABOVE)
				r.lvl = LVL_GREEN;
			else if (r.pct > PCT_AMBER_ABOVE)
				r.lvl = LVL_AMBER;
			else
				r.lvl = LVL_RED;
			readings_due.push_back(r);
		endfunction

		function void check_reading(logic [VOLT_W-1:0] v, logic [PCT_W-1:0] p,
				logic [LEVEL_W-1:0] l);
			reading_t r;
			if (readings_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_CAP)
					$display("%0t: result word with nothing due: %0d mV %0d %% level %0d",
						$time, v, p, l);
				return;
			end
			r = readings_due.pop_front();
			if (v !== r.volt || p !== r.pct || l !== r.lvl) begin
				faults++;
				if (faults <= REPORT_CAP)
					$display("%0t: mv/pct/level expected %0d/%0d/%0d, actual %0d/%0d/%0d",
						$time, r.volt, r.pct, r.lvl, v, p, l);
			end
		endfunction

		function int unsigned outstanding();
			return readings_due.size();
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// block and its inputs, all known from time zero
	// -----------------------------------------------------------------------
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic [RAW_W-1:0]      raw_sample   = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [VOLT_W-1:0]     voltage_mv;
	logic [PCT_W-1:0]      percent;
	logic [LEVEL_W-1:0]    level;

	gauge_tracker tracker;
	bit           idle_on       = 1'b0;  // random idling on both sides
	bit           long_hold_due = 1'b0;  // asks the result side for a long hold-off
	int unsigned  stall_left    = 0;
	int unsigned  samples_taken = 0;

	battery_level_monitor_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.raw_sample   (raw_sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.voltage_mv   (voltage_mv),
		.percent      (percent),
		.level        (level)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// result side: stall bursts, plus the long hold-off when asked; the hold
	// is counted here so the sample side keeps offering words meanwhile
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (long_hold_due) begin
			long_hold_due = 1'b0;
			stall_left    = LONG_HOLD;
		end
		if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 12)
			stall_left = $urandom_range(1, 18);
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// result word taken at this edge: check against the oldest reading due
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_reading(voltage_mv, percent, level);
	end

	// -----------------------------------------------------------------------
	// sample side
	// -----------------------------------------------------------------------
	// Offers one word, at times after a random gap; valid stays high between
	// back-to-back words and the payload holds while stalled.
	task automatic offer_sample(input logic [RAW_W-1:0] raw);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 99) < 15) begin
			gap = $urandom_range(1, 18);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		raw_sample   <= raw;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		tracker.take_sample(raw);
		samples_taken++;
	endtask

	// stop offering and wait until every reading due has come back
	task automatic drain();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.outstanding() != 0);
	endtask

	// writes all four registers; only called with the block idle
	task automatic apply_settings(input logic [GAIN_W-1:0] gain, input int offs,
			input int empty_v, input int full_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_VOLT_GAIN;
		cfg_wdata <= gain;
		@(posedge clk);
		cfg_index <= REG_VOLT_OFFSET;
		cfg_wdata <= CFG_DATA_W'(offs[OFFS_W-1:0]);
		@(posedge clk);
		cfg_index <= REG_CELL_EMPTY;
		cfg_wdata <= CFG_DATA_W'(empty_v);
		@(posedge clk);
		cfg_index <= REG_CELL_FULL;
		cfg_wdata <= CFG_DATA_W'(full_v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.set_calibration(gain, offs[OFFS_W-1:0], VOLT_W'(empty_v), VOLT_W'(full_v));
	endtask

	// -----------------------------------------------------------------------
	// stimulus
	// -----------------------------------------------------------------------
	initial begin
		int unsigned       phase;
		int unsigned       n_words;
		int unsigned       spread;
		int                centre;
		int                code;
		int                offs;
		int                empty_v;
		int                full_v;
		int                est;
		logic [GAIN_W-1:0] gain;

		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset calibration, ring fills up from empty
		idle_on = 1'b1;
		foreach (WARMUP[i])
			offer_sample(WARMUP[i]);
		drain();
		// largest gain and offset: saturates high, ring wraps here
		apply_settings('1, OFFS_LIMIT, int'(EMPTY_RST), int'(FULL_RST));
		offer_sample(12'hFFF);
		offer_sample(12'hFFF);
		drain();
		// zero gain, most negative offset: clamps at 0 mV
		apply_settings('0, -OFFS_LIMIT, 0, CELL_MAX);
		offer_sample(12'h000);
		offer_sample(12'h800);
		drain();
		// empty equal to full: percent set to 0 or 100 with no division
		apply_settings(GAIN_RST, 0, 5000, 5000);
		offer_sample(12'hFFF);
		offer_sample(12'h000);
		drain();
		// full below empty
		apply_settings(GAIN_RST, OFFS_LIMIT, CELL_MAX, 1);
		offer_sample(12'hFFF);
		offer_sample(12'h400);

		// random phases, each under its own calibration
		phase = 0;
		while (samples_taken < ITEMS_TOTAL) begin
			drain();
			case ($urandom_range(0, 5))
				0:       gain = '0;
				1:       gain = '1;
				2:       gain = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
				default: gain = GAIN_W'($urandom_range(40000, 500000));
			endcase
			case ($urandom_range(0, 3))
				0:       offs = -OFFS_LIMIT;
				1:       offs = OFFS_LIMIT;
				default: offs = int'($urandom_range(0, 2 * OFFS_LIMIT)) - OFFS_LIMIT;
			endcase
			centre = $urandom_range(0, RAW_MAX);
			case ($urandom_range(0, 3))
				0:       spread = 0;
				1:       spread = 64;
				2:       spread = 512;
				default: spread = RAW_MAX;
			endcase
			// rough voltage of the phase, so the limits land near it
			est = int'((longint'(centre) * gain) >> Q_FRAC) + offs;
			if (est < 0)
				est = 0;
			if (est > CELL_MAX)
				est = CELL_MAX;
			case ($urandom_range(0, 6))
				0: begin
					empty_v = 0;
					full_v  = CELL_MAX;
				end
				1: begin
					empty_v = CELL_MAX;
					full_v  = 1;
				end
				2: begin
					empty_v = $urandom_range(0, CELL_MAX);
					full_v  = $urandom_range(1, CELL_MAX);
				end
				3: begin
					empty_v = est;
					full_v  = (est == 0) ? 1 : est;
				end
				default: begin
					empty_v = est - int'($urandom_range(0, 1500));
					full_v  = est + int'($urandom_range(1, 1500));
					if (empty_v < 0)
						empty_v = 0;
					if (full_v > CELL_MAX)
						full_v = CELL_MAX;
				end
			endcase
			apply_settings(gain, offs, empty_v, full_v);

			idle_on = (samples_taken < ITEMS_TOTAL - TAIL_ITEMS) && ($urandom_range(0, 4) != 0);
			if (phase % 10 == 0 && samples_taken < ITEMS_TOTAL - TAIL_ITEMS)
				long_hold_due = 1'b1;

			n_words = $urandom_range(30, 120);
			if (n_words > ITEMS_TOTAL - samples_taken)
				n_words = ITEMS_TOTAL - samples_taken;
			repeat (n_words) begin
				case ($urandom_range(0, 9))
					0:       code = $urandom_range(0, RAW_MAX);
					1:       code = $urandom_range(0, 1) ? RAW_MAX : 0;
					default: begin
						code = centre + int'($urandom_range(0, 2 * spread)) - int'(spread);
						if (code < 0)
							code = 0;
						if (code > RAW_MAX)
							code = RAW_MAX;
					end
				endcase
				offer_sample(RAW_W'(code));
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.faults == 0 && tracker.outstanding() == 0)
			$display("battery_level_monitor_top: match");
		else
			$display("battery_level_monitor_top: mismatch");
		$finish;
	end

	// hang guard, several times the slowest correct run
	initial begin
		#(TIMEOUT_NS);
		$display("battery_level_monitor_top: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/blm_pkg.sv
src/blm_div.sv
src/battery_level_monitor_top.sv
tb/battery_level_monitor_top_tb.sv
